### rtl/tap_pkg.sv
// Shared constants, types and helpers for the tensor axis permuter.
// Used by tap_mac, tap_mem and tensor_axis_permute; depends on nothing.
`timescale 1ns / 1ps

package tap_pkg;

    localparam int MAX_DIMS     = 4;
    localparam int MAX_ELEMENTS = 4096;
    localparam int DATA_WIDTH   = 32;

    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int DIM_W        = $clog2(MAX_DIMS);
    localparam int STEP_W       = $clog2(MAX_DIMS + 1);

    // Register layout
    localparam int RANK_W       = 3;
    localparam int SIZE_W       = 8;
    localparam int NUM_SIZE     = 4;
    localparam int ORDER_W      = 8;
    localparam int FIELD_W      = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    // Accumulator of the multiply-add unit: holds the product of all extents
    localparam int ACC_W        = NUM_SIZE * SIZE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANK    = 3'd0,
        CFG_SIZE0   = 3'd1,
        CFG_SIZE1   = 3'd2,
        CFG_SIZE2   = 3'd3,
        CFG_SIZE3   = 3'd4,
        CFG_ORDER   = 3'd5,
        CFG_REVERSE = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_AXIS = 2'd1,
        ST_TOO_BIG  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOTAL,
        S_ADDR,
        S_OUT
    } t_state;

    // A zero extent counts as one
    function automatic logic [SIZE_W-1:0] f_extent(input logic [SIZE_W-1:0] size);
        return (size == '0) ? SIZE_W'(1) : size;
    endfunction

endpackage

### rtl/tap_mac.sv
// Shared multiply-add unit: acc * extent + coordinate.
// Depends on tap_pkg.
`timescale 1ns / 1ps

module tap_mac
    import tap_pkg::*;
(
    input  logic [ACC_W-1:0]  i_acc,
    input  logic [SIZE_W-1:0] i_mul,
    input  logic [SIZE_W-1:0] i_add,
    output logic [ACC_W-1:0]  o_sum
);

    logic [ACC_W+SIZE_W-1:0] w_full;

    assign w_full = {{SIZE_W{1'b0}}, i_acc} * {{ACC_W{1'b0}}, i_mul}
                  + {{ACC_W{1'b0}}, i_add};
    // The product of at most four 8-bit extents fits the accumulator
    assign o_sum  = w_full[ACC_W-1:0];

endmodule

### rtl/tap_mem.sv
// Element store: one write port, one read port with registered read data.
// Depends on tap_pkg.
`timescale 1ns / 1ps

module tap_mem
    import tap_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [ADDR_W-1:0]     i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_store [MAX_ELEMENTS];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_store[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tensor_axis_permute.sv
// Tensor axis permuter: loads a row-major tensor, then returns it with its axes permuted.
// Load beat: written to the store at the accept edge; busy stays low, one beat per cycle unless a
// register write takes that cycle. Fetch beat: the shared multiply-add unit builds the address in
// S_ADDR, one axis per cycle, then one store read; the strobe rises in S_OUT (an error beat skips S_ADDR).
// Next beat is taken back in S_IDLE. Config write: busy while the same unit rebuilds the element count.
// Reset (synchronous, active low) restores register defaults; results cannot stall.
`timescale 1ns / 1ps

module tensor_axis_permute
    import tap_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [DATA_WIDTH-1:0] i_element_in,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // result channel
    output logic                  o_result_strobe,
    output logic [DATA_WIDTH-1:0] o_element_out,
    output logic                  o_is_last,
    output logic [1:0]            o_status
);

    // ------------------------------------------------------------------
    // Registers and their next values
    // ------------------------------------------------------------------
    logic [RANK_W-1:0]  r_rank,     n_rank;
    logic [SIZE_W-1:0]  r_size      [NUM_SIZE];
    logic [SIZE_W-1:0]  n_size      [NUM_SIZE];
    logic [ORDER_W-1:0] r_order,    n_order;
    logic               r_reverse,  n_reverse;

    t_state             r_state,    n_state;
    logic [STEP_W-1:0]  r_step,     n_step;
    logic [ACC_W-1:0]   r_acc,      n_acc;
    logic [ACC_W-1:0]   r_total,    n_total;
    logic [ADDR_W-1:0]  r_load_ptr, n_load_ptr;
    logic [ADDR_W-1:0]  r_out_count, n_out_count;
    logic [SIZE_W-1:0]  r_coords    [MAX_DIMS];
    logic [SIZE_W-1:0]  n_coords    [MAX_DIMS];
    t_status            r_status,   n_status;
    logic               r_last,     n_last;

    // ------------------------------------------------------------------
    // Derived configuration
    // ------------------------------------------------------------------
    logic [RANK_W-1:0]  w_rank;
    logic [SIZE_W-1:0]  w_ext       [MAX_DIMS];
    logic [DIM_W-1:0]   w_perm      [MAX_DIMS];
    logic               w_bad_axis;
    logic               w_too_big;

    // Clamp rank to the supported number of axes
    assign w_rank = (r_rank > RANK_W'(MAX_DIMS)) ? RANK_W'(MAX_DIMS) : r_rank;

    // Extent and source axis of every position; axes past the register set
    // have extent one and an axis field of zero
    for (genvar g = 0; g < MAX_DIMS; g++) begin : g_axis
        logic [DIM_W-1:0] w_field;
        if (g < NUM_SIZE) begin : g_reg
            assign w_ext[g]  = f_extent(r_size[g]);
            assign w_field   = DIM_W'(r_order[FIELD_W*g +: FIELD_W]);
        end else begin : g_pad
            assign w_ext[g]  = SIZE_W'(1);
            assign w_field   = '0;
        end

        always_comb begin
            if (w_rank <= RANK_W'(1)) begin
                w_perm[g] = DIM_W'(g);
            end else if (r_reverse) begin
                if (RANK_W'(g) < w_rank) begin
                    w_perm[g] = DIM_W'(w_rank - RANK_W'(1) - RANK_W'(g));
                end else begin
                    w_perm[g] = DIM_W'(g);
                end
            end else begin
                w_perm[g] = w_field;
            end
        end
    end

    // Flag an explicit order that names a missing axis or names one twice
    always_comb begin
        w_bad_axis = 1'b0;
        if (w_rank >= RANK_W'(2) && !r_reverse) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                if (RANK_W'(i) < w_rank) begin
                    if (RANK_W'(w_perm[i]) >= w_rank) begin
                        w_bad_axis = 1'b1;
                    end
                    for (int j = 0; j < MAX_DIMS; j++) begin
                        if (j < i && w_perm[j] == w_perm[i]) begin
                            w_bad_axis = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign w_too_big = (r_total > ACC_W'(MAX_ELEMENTS));

    // ------------------------------------------------------------------
    // Walk helpers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] w_src  [MAX_DIMS];
    logic [SIZE_W-1:0] w_next [MAX_DIMS];
    logic [ADDR_W:0]   w_ptr_inc;
    logic              w_ptr_wrap;
    logic [ADDR_W:0]   w_count_inc;
    logic              w_is_last;
    logic              w_step_live;

    // Scatter output coordinates onto source axes
    always_comb begin
        for (int j = 0; j < MAX_DIMS; j++) begin
            w_src[j] = '0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                if (RANK_W'(i) < w_rank && w_perm[i] == DIM_W'(j)) begin
                    w_src[j] = r_coords[i];
                end
            end
        end
    end

    // Odometer: advance the last output axis, carry toward the first
    always_comb begin
        logic             carry;
        logic [SIZE_W:0]  inc;
        carry = 1'b1;
        for (int k = MAX_DIMS - 1; k >= 0; k--) begin
            inc       = {1'b0, r_coords[k]} + (SIZE_W+1)'(1);
            w_next[k] = r_coords[k];
            if (RANK_W'(k) < w_rank && carry) begin
                if (inc < {1'b0, w_ext[w_perm[k]]}) begin
                    w_next[k] = inc[SIZE_W-1:0];
                    carry     = 1'b0;
                end else begin
                    w_next[k] = '0;
                end
            end
        end
    end

    assign w_ptr_inc   = {1'b0, r_load_ptr} + (ADDR_W+1)'(1);
    assign w_ptr_wrap  = w_too_big ? w_ptr_inc[ADDR_W]
                                   : (ACC_W'(w_ptr_inc) >= r_total);
    assign w_count_inc = {1'b0, r_out_count} + (ADDR_W+1)'(1);
    assign w_is_last   = (ACC_W'(w_count_inc) >= r_total);
    assign w_step_live = (r_step < STEP_W'(w_rank));

    // ------------------------------------------------------------------
    // Shared multiply-add unit: element count in S_TOTAL, address in S_ADDR
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  w_axis;
    logic [SIZE_W-1:0] w_mul_op;
    logic [SIZE_W-1:0] w_add_op;
    logic [ACC_W-1:0]  w_mac;

    assign w_axis   = r_step[DIM_W-1:0];
    assign w_mul_op = w_ext[w_axis];
    assign w_add_op = (r_state == S_ADDR) ? w_src[w_axis] : '0;

    tap_mac u_mac (
        .i_acc (r_acc),
        .i_mul (w_mul_op),
        .i_add (w_add_op),
        .o_sum (w_mac)
    );

    // ------------------------------------------------------------------
    // Element store
    // ------------------------------------------------------------------
    logic                  w_mem_we;
    logic                  w_mem_re;
    logic [DATA_WIDTH-1:0] w_mem_rdata;

    tap_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_load_ptr),
        .i_wdata (i_element_in),
        .i_re    (w_mem_re),
        .i_raddr (r_acc[ADDR_W-1:0]),
        .o_rdata (w_mem_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state and outputs
    // ------------------------------------------------------------------
    logic w_cfg_hit;

    always_comb begin
        n_rank      = r_rank;
        n_size      = r_size;
        n_order     = r_order;
        n_reverse   = r_reverse;
        n_state     = r_state;
        n_step      = r_step;
        n_acc       = r_acc;
        n_total     = r_total;
        n_load_ptr  = r_load_ptr;
        n_out_count = r_out_count;
        n_coords    = r_coords;
        n_status    = r_status;
        n_last      = r_last;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_cfg_hit   = 1'b0;

        // Register writes take priority over the sequencer; an unknown index does nothing
        if (i_cfg_we) begin
            w_cfg_hit = 1'b1;
            unique case (i_cfg_index)
                CFG_RANK:    n_rank    = i_cfg_data[RANK_W-1:0];
                CFG_SIZE0:   n_size[0] = i_cfg_data[SIZE_W-1:0];
                CFG_SIZE1:   n_size[1] = i_cfg_data[SIZE_W-1:0];
                CFG_SIZE2:   n_size[2] = i_cfg_data[SIZE_W-1:0];
                CFG_SIZE3:   n_size[3] = i_cfg_data[SIZE_W-1:0];
                CFG_ORDER:   n_order   = i_cfg_data[ORDER_W-1:0];
                CFG_REVERSE: n_reverse = i_cfg_data[0];
                default:     w_cfg_hit = 1'b0;
            endcase
        end

        if (w_cfg_hit) begin
            // Restart walk and load pointer, then rebuild the element count
            n_load_ptr  = '0;
            n_out_count = '0;
            for (int k = 0; k < MAX_DIMS; k++) begin
                n_coords[k] = '0;
            end
            n_acc   = ACC_W'(1);
            n_step  = '0;
            n_state = S_TOTAL;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (!i_action) begin
                            // Load beat: store and advance, wrap at shape end
                            w_mem_we   = 1'b1;
                            n_load_ptr = w_ptr_wrap ? '0 : w_ptr_inc[ADDR_W-1:0];
                        end else if (w_bad_axis) begin
                            n_status = ST_BAD_AXIS;
                            n_last   = 1'b0;
                            n_state  = S_OUT;
                        end else if (w_too_big) begin
                            n_status = ST_TOO_BIG;
                            n_last   = 1'b0;
                            n_state  = S_OUT;
                        end else begin
                            n_status = ST_OK;
                            n_acc    = '0;
                            n_step   = '0;
                            n_state  = S_ADDR;
                        end
                    end
                end
                S_TOTAL: begin
                    if (w_step_live) begin
                        n_acc  = w_mac;
                        n_step = r_step + STEP_W'(1);
                    end else begin
                        n_total = r_acc;
                        n_state = S_IDLE;
                    end
                end
                S_ADDR: begin
                    if (w_step_live) begin
                        n_acc  = w_mac;
                        n_step = r_step + STEP_W'(1);
                    end else begin
                        // Address done: read the element and advance the walk
                        w_mem_re = 1'b1;
                        n_state  = S_OUT;
                        n_last   = w_is_last;
                        if (w_is_last) begin
                            n_out_count = '0;
                            for (int k = 0; k < MAX_DIMS; k++) begin
                                n_coords[k] = '0;
                            end
                        end else begin
                            n_out_count = w_count_inc[ADDR_W-1:0];
                            n_coords    = w_next;
                        end
                    end
                end
                S_OUT: begin
                    n_state = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank      <= RANK_W'(1);
            for (int k = 0; k < NUM_SIZE; k++) begin
                r_size[k] <= SIZE_W'(1);
            end
            r_order     <= ORDER_W'(228);
            r_reverse   <= 1'b1;
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_total     <= ACC_W'(1);
            r_load_ptr  <= '0;
            r_out_count <= '0;
            for (int k = 0; k < MAX_DIMS; k++) begin
                r_coords[k] <= '0;
            end
            r_status    <= ST_OK;
            r_last      <= 1'b0;
        end else begin
            r_rank      <= n_rank;
            r_size      <= n_size;
            r_order     <= n_order;
            r_reverse   <= n_reverse;
            r_state     <= n_state;
            r_step      <= n_step;
            r_total     <= n_total;
            r_load_ptr  <= n_load_ptr;
            r_out_count <= n_out_count;
            r_coords    <= n_coords;
            r_status    <= n_status;
            r_last      <= n_last;
        end
    end

    // Accumulator is payload: no reset
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // ------------------------------------------------------------------
    // Outputs: drop the element on an error beat
    // ------------------------------------------------------------------
    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = (r_state == S_OUT);
    assign o_element_out   = (r_status == ST_OK) ? w_mem_rdata : '0;
    assign o_is_last       = r_last;
    assign o_status        = r_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_beat_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_status != ST_OK) |-> (!o_is_last && o_element_out == '0))
        else $error("error beat carries data or last flag");

    a_idle_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !i_cfg_we) |=> !busy)
        else $error("sequencer did not return to idle after a result beat");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ACC_W'(r_out_count) < r_total)
        else $error("output count reached the element count");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total != '0)
        else $error("element count is zero");

endmodule
